// ===== src/wrwm_pkg.sv =====
// Package: shared widths, constants and payload types of the wear meter.
package wrwm_pkg;

   localparam int ACC_W     = 55;
   localparam int TIME_W    = 32;
   localparam int SPEED_W   = 15;
   localparam int PROD_W    = TIME_W + SPEED_W;
   localparam int CSR_W     = 24;
   localparam int PDIV_W    = 40;
   localparam int PCT_W     = 15;
   localparam int HOURS_W   = 27;
   localparam int DAYS_W    = 22;
   localparam int MINUTE_W  = 25;
   localparam int QUO_W     = 27;
   localparam int STEP_W    = 5;
   localparam int SDIV_W    = ACC_W + 1;

   // ms x Q8 percent units
   localparam longint UNITS_PER_MINUTE  = 64'd1536000000;
   localparam longint UNITS_PER_HOUR_Q8 = 64'd360000000;
   localparam longint UNITS_PER_DAY_Q8  = 64'd8640000000;
   localparam longint MS_PER_MINUTE     = 64'd60000;

   localparam logic [SPEED_W-1:0] FULL_SPEED_Q8 = 15'd25600;
   localparam logic [ACC_W-1:0]   ACC_MAX       = '1;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   // quotient bits per division
   localparam logic [STEP_W-1:0] MINUTE_STEPS = 5'd25;
   localparam logic [STEP_W-1:0] HOURS_STEPS  = 5'd27;
   localparam logic [STEP_W-1:0] PCT_STEPS    = 5'd15;
   localparam logic [STEP_W-1:0] DAYS_STEPS   = 5'd22;

   // divisors pre-aligned to the top quotient bit
   localparam logic [SDIV_W-1:0] SDIV_MINUTE =
      SDIV_W'(UNITS_PER_MINUTE) << (MINUTE_STEPS - 5'd1);
   localparam logic [SDIV_W-1:0] SDIV_HOUR =
      SDIV_W'(UNITS_PER_HOUR_Q8) << (HOURS_STEPS - 5'd1);
   localparam logic [SDIV_W-1:0] SDIV_DAY =
      SDIV_W'(UNITS_PER_DAY_Q8) << (DAYS_STEPS - 5'd1);

   typedef struct packed {
      logic                      opcode;
      logic [TIME_W-1:0]         now_ms;
      logic                      unit_on;
      logic signed [CSR_W-1:0]   speed_pct_q8;
      logic                      speed_valid;
   } req_type;

   typedef struct packed {
      logic [PCT_W-1:0]   remaining_pct_q8;
      logic [HOURS_W-1:0] runtime_hours_q8;
      logic [DAYS_W-1:0]  remaining_days_q8;
      logic               save_request;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [STEP_W-1:0] steps;
      logic [ACC_W-1:0]  dividend;
      logic [SDIV_W-1:0] sdiv;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ===== src/wrwm_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
module wrwm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  wrwm_pkg::div_req_type div_req,
   output wrwm_pkg::div_rsp_type div_rsp
);

   logic [wrwm_pkg::ACC_W-1:0]  rem_ff, rem_in;
   logic [wrwm_pkg::SDIV_W-1:0] sdiv_ff, sdiv_in;
   logic [wrwm_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [wrwm_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic                        ge;

   always_comb begin
      ge      = {1'b0, rem_ff} >= sdiv_ff;
      rem_in  = rem_ff;
      sdiv_in = sdiv_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = div_req.dividend;
         sdiv_in = div_req.sdiv;
         quo_in  = '0;
         cnt_in  = div_req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - sdiv_ff[wrwm_pkg::ACC_W-1:0];
         end
         quo_in  = {quo_ff[wrwm_pkg::QUO_W-2:0], ge};
         sdiv_in = sdiv_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == wrwm_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      sdiv_ff <= sdiv_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ===== src/weighted_runtime_wear_meter_core.sv =====
// Top level: weighted runtime wear meter with serial multiplier and two serial dividers.
// Requests are taken only while idle. An update runs the 15-step shift-add multiplier first;
// both kinds then wait on the 25-step minute pass and the 27-step hours pass of the dividers.
// A finished result waits in the output register while the next request is taken.
// Reset (synchronous): clears runtime, timestamp, lifetime and result valid; ready at once.
module weighted_runtime_wear_meter_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  wrwm_pkg::req_type          req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output wrwm_pkg::rsp_type          rsp_data,
   input  logic                       csr_write_enable,
   input  logic [wrwm_pkg::CSR_W-1:0] csr_write_data
);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_DIFF  = 3'd3;
   localparam logic [2:0] ST_DIVA  = 3'd4;
   localparam logic [2:0] ST_WAITA = 3'd5;
   localparam logic [2:0] ST_WAITB = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   localparam int MCNT_W = $clog2(wrwm_pkg::SPEED_W + 1);

   logic [2:0]                     state_ff, state_in;
   logic [wrwm_pkg::CSR_W-1:0]     csr_ff, csr_in;
   logic [wrwm_pkg::ACC_W-1:0]     life_ff, life_in;
   logic [wrwm_pkg::PDIV_W-1:0]    pdiv_ff, pdiv_in;
   logic [wrwm_pkg::TIME_W-1:0]    last_ff, last_in;
   logic [wrwm_pkg::ACC_W-1:0]     accum_ff, accum_in;
   logic [wrwm_pkg::MINUTE_W-1:0]  minutes_ff, minutes_in;
   logic [wrwm_pkg::PROD_W-1:0]    mcand_ff, mcand_in;
   logic [wrwm_pkg::SPEED_W-1:0]   mplier_ff, mplier_in;
   logic [wrwm_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic [MCNT_W-1:0]              mcnt_ff, mcnt_in;
   logic                           on_ff, on_in;
   logic                           op_ff, op_in;
   logic [wrwm_pkg::ACC_W-1:0]     d_ff, d_in;
   logic [wrwm_pkg::PCT_W-1:0]     pct_ff, pct_in;
   logic                           save_ff, save_in;
   wrwm_pkg::rsp_type              rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   logic [wrwm_pkg::SPEED_W-1:0]   speed_clamped;
   logic [wrwm_pkg::TIME_W-1:0]    elapsed;
   logic [wrwm_pkg::ACC_W:0]       acc_sum;
   logic [wrwm_pkg::MINUTE_W-1:0]  minutes_new;
   logic                           req_take;
   logic                           rsp_free;

   wrwm_pkg::div_req_type          div0_req, div1_req;
   wrwm_pkg::div_rsp_type          div0_rsp, div1_rsp;

   // unit 0: whole minutes, then days; unit 1: percentage, then hours
   wrwm_div u_div0 (
      .clock   (clock),
      .reset   (reset),
      .div_req (div0_req),
      .div_rsp (div0_rsp)
   );

   wrwm_div u_div1 (
      .clock   (clock),
      .reset   (reset),
      .div_req (div1_req),
      .div_rsp (div1_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Speed clamp: invalid or negative reads as zero, above full speed reads as full
   always_comb begin
      if (!req_data.speed_valid || req_data.speed_pct_q8[wrwm_pkg::CSR_W-1]) begin
         speed_clamped = '0;
      end else if (req_data.speed_pct_q8[wrwm_pkg::CSR_W-2:0] >
                   (wrwm_pkg::CSR_W-1)'(wrwm_pkg::FULL_SPEED_Q8)) begin
         speed_clamped = wrwm_pkg::FULL_SPEED_Q8;
      end else begin
         speed_clamped = req_data.speed_pct_q8[wrwm_pkg::SPEED_W-1:0];
      end
   end

   // elapsed time wraps at the timestamp width
   assign elapsed     = req_data.now_ms - last_ff;
   assign acc_sum     = {1'b0, accum_ff} + (wrwm_pkg::ACC_W+1)'(prod_ff);
   assign minutes_new = div0_rsp.quotient[wrwm_pkg::MINUTE_W-1:0];

   // Lifetime products follow the register; config must only change while idle (the block does
   // not enforce this), well before either product is first used by a request.
   assign life_in = wrwm_pkg::ACC_W'(csr_ff) * wrwm_pkg::ACC_W'(wrwm_pkg::UNITS_PER_MINUTE);
   assign pdiv_in = wrwm_pkg::PDIV_W'(csr_ff) * wrwm_pkg::PDIV_W'(wrwm_pkg::MS_PER_MINUTE);
   assign csr_in  = csr_write_enable ? csr_write_data : csr_ff;

   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      accum_in     = accum_ff;
      minutes_in   = minutes_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      prod_in      = prod_ff;
      mcnt_in      = mcnt_ff;
      on_in        = on_ff;
      op_in        = op_ff;
      d_in         = d_ff;
      pct_in       = pct_ff;
      save_in      = save_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      div0_req          = '0;
      div0_req.dividend = accum_ff;
      div0_req.sdiv     = wrwm_pkg::SDIV_MINUTE;
      div0_req.steps    = wrwm_pkg::MINUTE_STEPS;
      div1_req          = '0;
      div1_req.dividend = d_ff;
      div1_req.sdiv     = wrwm_pkg::SDIV_W'(pdiv_ff) << (wrwm_pkg::PCT_STEPS - 5'd1);
      div1_req.steps    = wrwm_pkg::PCT_STEPS;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in = req_data.opcode;
               if (req_data.opcode == wrwm_pkg::OP_CLEAR) begin
                  // clear keeps the timestamp; result comes from the zeroed runtime
                  accum_in = '0;
                  on_in    = 1'b0;
                  state_in = ST_DIFF;
               end else begin
                  last_in   = req_data.now_ms;
                  mcand_in  = wrwm_pkg::PROD_W'(elapsed);
                  mplier_in = speed_clamped;
                  prod_in   = '0;
                  mcnt_in   = MCNT_W'(wrwm_pkg::SPEED_W);
                  on_in     = req_data.unit_on;
                  state_in  = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            // shift-add, one speed bit per cycle
            if (mplier_ff[0]) begin
               prod_in = prod_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            mcnt_in   = mcnt_ff - 1'b1;
            if (mcnt_ff == MCNT_W'(1)) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (on_ff) begin
               accum_in = acc_sum[wrwm_pkg::ACC_W] ? wrwm_pkg::ACC_MAX
                                                   : acc_sum[wrwm_pkg::ACC_W-1:0];
            end
            state_in = ST_DIFF;
         end
         ST_DIFF: begin
            d_in     = (life_ff > accum_ff) ? (life_ff - accum_ff) : '0;
            state_in = ST_DIVA;
         end
         ST_DIVA: begin
            div0_req.start = 1'b1;
            div1_req.start = 1'b1;
            state_in       = ST_WAITA;
         end
         ST_WAITA: begin
            // percentage finished earlier than the minute count
            if (div0_rsp.done) begin
               pct_in     = div1_rsp.quotient[wrwm_pkg::PCT_W-1:0];
               save_in    = (op_ff == wrwm_pkg::OP_CLEAR) ||
                            (on_ff && (minutes_new != minutes_ff));
               minutes_in = minutes_new;

               div0_req.start    = 1'b1;
               div0_req.dividend = d_ff;
               div0_req.sdiv     = wrwm_pkg::SDIV_DAY;
               div0_req.steps    = wrwm_pkg::DAYS_STEPS;
               div1_req.start    = 1'b1;
               div1_req.dividend = accum_ff;
               div1_req.sdiv     = wrwm_pkg::SDIV_HOUR;
               div1_req.steps    = wrwm_pkg::HOURS_STEPS;
               state_in          = ST_WAITB;
            end
         end
         ST_WAITB: begin
            if (div1_rsp.done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_in.remaining_pct_q8  = (csr_ff == '0) ? wrwm_pkg::FULL_SPEED_Q8 : pct_ff;
               rsp_in.runtime_hours_q8  = div1_rsp.quotient[wrwm_pkg::HOURS_W-1:0];
               rsp_in.remaining_days_q8 = div0_rsp.quotient[wrwm_pkg::DAYS_W-1:0];
               rsp_in.save_request      = save_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         csr_ff       <= '0;
         last_ff      <= '0;
         accum_ff     <= '0;
         minutes_ff   <= '0;
         mcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_ff       <= csr_in;
         last_ff      <= last_in;
         accum_ff     <= accum_in;
         minutes_ff   <= minutes_in;
         mcnt_ff      <= mcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      life_ff   <= life_in;
      pdiv_ff   <= pdiv_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
      on_ff     <= on_in;
      op_ff     <= op_in;
      d_ff      <= d_in;
      pct_ff    <= pct_in;
      save_ff   <= save_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/wrwm_checker.sv =====
// Port-level checker for the wear meter core, with its bind.
module wrwm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input wrwm_pkg::rsp_type rsp_data
);

   a_reset_clears_rsp : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_rsp_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.remaining_pct_q8 <= wrwm_pkg::FULL_SPEED_Q8) &&
                    (rsp_data.remaining_days_q8 <= wrwm_pkg::DAYS_W'(2982616)))
      else $error("result field out of range");

   a_no_instant_rsp : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$rose(rsp_valid))
      else $error("result appeared straight after a request");

endmodule

bind weighted_runtime_wear_meter_core wrwm_checker u_wrwm_checker (.*);

// ===== tb/sv/testbench.sv =====
// Testbench for the weighted runtime wear meter: directed table, random phases, self-checking.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // Arithmetic of the meter: ms x Q8 percent units
   localparam bit [63:0] MINUTE_UNITS  = 64'd1536000000;
   localparam bit [63:0] HOUR_UNITS_Q8 = 64'd360000000;
   localparam bit [63:0] DAY_UNITS_Q8  = 64'd8640000000;
   localparam bit [63:0] MS_PER_MIN    = 64'd60000;
   localparam bit [63:0] FULL_SPEED    = 64'd25600;
   localparam bit [63:0] RUNTIME_LIMIT = (64'd1 << 55) - 64'd1;

   localparam int MAX_GAP         = 16;
   localparam int HOLD_OFF_CYCLES = 600;   // long receiver hold-off, fills the pipe
   localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no handshake at all
   localparam int SETTLE_CYCLES   = 100;   // beyond the update latency
   localparam int PRINT_CAP       = 60;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   wrwm_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   wrwm_pkg::rsp_type rsp_data;
   logic              csr_write_enable;
   logic [wrwm_pkg::CSR_W-1:0] csr_write_data;

   weighted_runtime_wear_meter_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Shadow state of the meter, advanced once per accepted request
   // ---------------------------------------------------------------------
   bit [63:0] runtime_units;   // 55-bit saturating accumulator
   bit [31:0] last_stamp_ms;
   bit [23:0] life_minutes;

   wrwm_pkg::rsp_type expected_rsp[$];   // results still owed by the block, oldest first
   int      mismatches;
   int      idle_cycles;
   bit      sender_steady;     // no gaps between requests
   bit      receiver_steady;   // no stalls on the result side
   bit      hold_off_pending;  // asks the receiver for one long hold-off

   typedef struct {
      bit                do_cfg;
      bit [23:0]         cfg;
      wrwm_pkg::req_type req;
      bit                typed;
      wrwm_pkg::rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   // Works out the result of one request and updates the shadow state.
   function automatic wrwm_pkg::rsp_type wear_predict(wrwm_pkg::req_type r);
      wrwm_pkg::rsp_type res;
      bit [31:0] elapsed;
      bit [63:0] spd;
      bit [63:0] add;
      bit [63:0] minutes_before;
      bit [63:0] life_units;
      bit [63:0] headroom;
      bit [63:0] q;
      bit        save;
      save = 1'b0;
      if (r.opcode == wrwm_pkg::OP_CLEAR) begin
         // clear: timestamp kept, other fields ignored, always persisted
         runtime_units = '0;
         save = 1'b1;
      end else begin
         elapsed = r.now_ms - last_stamp_ms;   // wraps modulo 2^32
         last_stamp_ms = r.now_ms;
         // invalid or negative speed counts as zero, above 100% as 100%
         if (!r.speed_valid || r.speed_pct_q8[23])
            spd = 64'd0;
         else if (64'(r.speed_pct_q8[22:0]) > FULL_SPEED)
            spd = FULL_SPEED;
         else
            spd = 64'(r.speed_pct_q8[22:0]);
         if (r.unit_on) begin
            minutes_before = runtime_units / MINUTE_UNITS;
            add = 64'(elapsed) * spd;
            if (add > RUNTIME_LIMIT - runtime_units)
               runtime_units = RUNTIME_LIMIT;
            else
               runtime_units = runtime_units + add;
            save = (runtime_units / MINUTE_UNITS) != minutes_before;
         end
      end
      life_units = 64'(life_minutes) * MINUTE_UNITS;
      headroom = (life_units > runtime_units) ? life_units - runtime_units : 64'd0;
      if (life_minutes == 24'd0)
         q = FULL_SPEED;
      else
         q = headroom / (64'(life_minutes) * MS_PER_MIN);
      res.remaining_pct_q8 = q[wrwm_pkg::PCT_W-1:0];
      q = runtime_units / HOUR_UNITS_Q8;
      res.runtime_hours_q8 = q[wrwm_pkg::HOURS_W-1:0];
      q = headroom / DAY_UNITS_Q8;
      res.remaining_days_q8 = q[wrwm_pkg::DAYS_W-1:0];
      res.save_request = save;
      return res;
   endfunction

   function automatic wrwm_pkg::rsp_type rsp_of(int pct, int hours, int days, bit save);
      wrwm_pkg::rsp_type r;
      r.remaining_pct_q8  = wrwm_pkg::PCT_W'(pct);
      r.runtime_hours_q8  = wrwm_pkg::HOURS_W'(hours);
      r.remaining_days_q8 = wrwm_pkg::DAYS_W'(days);
      r.save_request      = save;
      return r;
   endfunction

   function automatic stim_row_type mk_row(bit do_cfg, bit [23:0] cfg, logic op,
                                           bit [31:0] now, bit on, bit [23:0] spd,
                                           bit spd_ok, bit typed, wrwm_pkg::rsp_type want);
      stim_row_type row;
      row.do_cfg           = do_cfg;
      row.cfg              = cfg;
      row.req.opcode       = op;
      row.req.now_ms       = now;
      row.req.unit_on      = on;
      row.req.speed_pct_q8 = spd;
      row.req.speed_valid  = spd_ok;
      row.typed            = typed;
      row.want             = want;
      return row;
   endfunction

   // Ordinary traffic: mostly sane updates from the last timestamp, some clears and junk speeds.
   function automatic wrwm_pkg::req_type random_request();
      wrwm_pkg::req_type r;
      bit [31:0]         elapsed;
      case ($urandom_range(0, 9)) inside
         [0:5]:   elapsed = $urandom_range(0, 200000);
         [6:7]:   elapsed = $urandom_range(0, 3000000);
         8:       elapsed = $urandom;
         default: elapsed = 32'd0;
      endcase
      r.opcode = ($urandom_range(0, 99) < 4) ? wrwm_pkg::OP_CLEAR : wrwm_pkg::OP_UPDATE;
      r.now_ms = (r.opcode == wrwm_pkg::OP_CLEAR) ? $urandom : last_stamp_ms + elapsed;
      r.unit_on = ($urandom_range(0, 9) < 8);
      case ($urandom_range(0, 9)) inside
         [0:6]:   r.speed_pct_q8 = 24'($urandom_range(0, 25600));
         7:       r.speed_pct_q8 = 24'd25600;
         8:       r.speed_pct_q8 = 24'($urandom_range(25601, 8388607));
         default: r.speed_pct_q8 = 24'($urandom);
      endcase
      r.speed_valid = ($urandom_range(0, 9) != 0);
      return r;
   endfunction

   // Wear-out traffic: longest possible interval at full (or clamped) speed.
   function automatic wrwm_pkg::req_type wear_out_request();
      wrwm_pkg::req_type r;
      r.opcode       = wrwm_pkg::OP_UPDATE;
      r.now_ms       = last_stamp_ms - 32'd1;
      r.unit_on      = 1'b1;
      r.speed_pct_q8 = ($urandom_range(0, 3) == 0) ? 24'($urandom_range(25601, 8388607))
                                                   : 24'd25600;
      r.speed_valid  = 1'b1;
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      if (mismatches < PRINT_CAP)
         $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   // Offers one request and holds it until taken; the expectation is queued at acceptance.
   task automatic send_request(wrwm_pkg::req_type r, bit typed, wrwm_pkg::rsp_type typed_rsp);
      wrwm_pkg::rsp_type predicted;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      predicted = wear_predict(r);
      expected_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic sender_gap();
      int gap;
      gap = sender_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Block must be idle before the lifetime register changes.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_lifetime(bit [23:0] minutes);
      csr_write_enable <= 1'b1;
      csr_write_data   <= minutes;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      life_minutes = minutes;
   endtask

   task automatic run_phase(bit [23:0] minutes, int count, bit wear_out);
      wrwm_pkg::req_type r;
      wrwm_pkg::rsp_type none;
      none = '0;
      drain();
      write_lifetime(minutes);
      sender_steady   = ($urandom_range(0, 2) == 0);
      receiver_steady = ($urandom_range(0, 2) == 0);
      for (int i = 0; i < count; i++) begin
         r = wear_out ? wear_out_request() : random_request();
         if (wear_out && i == 25)
            hold_off_pending = 1'b1;
         send_request(r, 1'b0, none);
         sender_gap();
      end
   endtask

   // ---------------------------------------------------------------------
   // Result side: random stalls, plus one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      int hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold = HOLD_OFF_CYCLES;
         end else begin
            hold = receiver_steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Result checker: every accepted result against the oldest expectation.
   always @(posedge clock) begin
      wrwm_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("result with no request outstanding, hours",
                            rsp_data.runtime_hours_q8, 0);
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_data.remaining_pct_q8 !== want.remaining_pct_q8)
               report_mismatch("remaining_pct_q8", rsp_data.remaining_pct_q8,
                               want.remaining_pct_q8);
            if (rsp_data.runtime_hours_q8 !== want.runtime_hours_q8)
               report_mismatch("runtime_hours_q8", rsp_data.runtime_hours_q8,
                               want.runtime_hours_q8);
            if (rsp_data.remaining_days_q8 !== want.remaining_days_q8)
               report_mismatch("remaining_days_q8", rsp_data.remaining_days_q8,
                               want.remaining_days_q8);
            if (rsp_data.save_request !== want.save_request)
               report_mismatch("save_request", rsp_data.save_request, want.save_request);
         end
      end
   end

   // Watchdog: any handshake on either side counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      wrwm_pkg::rsp_type none;
      none = '0;
      mismatches       = 0;
      idle_cycles      = 0;
      hold_off_pending = 1'b0;
      sender_steady    = 1'b0;
      receiver_steady  = 1'b0;
      runtime_units    = '0;
      last_stamp_ms    = '0;
      life_minutes     = '0;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_data         <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;

      // Directed table. Zero lifetime first: percentage pinned at 100, days at 0.
      // after reset, nothing elapsed
      directed_rows.push_back(mk_row(1, 24'd0, wrwm_pkg::OP_UPDATE, 32'd0, 1, 24'd25600, 1,
                                     1, rsp_of(25600, 0, 0, 0)));
      // one full-speed minute: minute count changes, save raised
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd60000, 1, 24'd25600,
                                     1, 1, rsp_of(25600, 4, 0, 1)));
      // clear with junk in the ignored fields, timestamp kept
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_CLEAR, 32'hDEADBEEF, 1,
                                     24'h7FFFFF, 1, 1, rsp_of(25600, 0, 0, 1)));
      // unit off: nothing accrues, timestamp still taken
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'hFFFFFFFF, 0,
                                     24'd25600, 1, 1, rsp_of(25600, 0, 0, 0)));
      // timestamp wrap: 59999 after all-ones is 60000 ms
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd59999, 1, 24'd25600,
                                     1, 1, rsp_of(25600, 4, 0, 1)));
      // most negative speed counts as zero
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd60099, 1, 24'h800000,
                                     1, 1, rsp_of(25600, 4, 0, 0)));
      // most positive speed clamps to 100%
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd60199, 1, 24'h7FFFFF,
                                     1, 0, none));
      // invalid speed counts as zero
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd120199, 1, 24'd25600,
                                     0, 0, none));
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd180199, 1, 24'hFFFFFF,
                                     1, 0, none));
      // half speed
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd240199, 1, 24'd12800,
                                     1, 0, none));
      // one-minute lifetime, fresh after clear
      directed_rows.push_back(mk_row(1, 24'd1, wrwm_pkg::OP_CLEAR, 32'd0, 0, 24'd0, 0,
                                     1, rsp_of(25600, 0, 0, 1)));
      // runtime past lifetime: percentage and days clamp at zero
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd360199, 1, 24'd25600,
                                     1, 1, rsp_of(0, 8, 0, 1)));
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'd0, 0, 24'd25600, 1,
                                     0, none));
      // longest lifetime, fresh after clear
      directed_rows.push_back(mk_row(1, 24'hFFFFFF, wrwm_pkg::OP_CLEAR, 32'h55555555, 1,
                                     24'h555555, 0, 1, rsp_of(25600, 0, 2982616, 1)));
      // longest interval at full speed, then at the smallest speed
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'hFFFFFFFF, 1,
                                     24'd25600, 1, 0, none));
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'hFFFFFFFE, 1, 24'd1,
                                     1, 0, none));
      directed_rows.push_back(mk_row(1, 24'd1000, wrwm_pkg::OP_UPDATE, 32'h12345678, 0,
                                     24'h555555, 1, 0, none));
      directed_rows.push_back(mk_row(0, 24'd0, wrwm_pkg::OP_UPDATE, 32'h1234B122, 1,
                                     24'h002AAA, 1, 0, none));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].do_cfg) begin
            if (i != 0)
               drain();
            write_lifetime(directed_rows[i].cfg);
         end
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
         sender_gap();
      end

      // Random phases over several lifetimes, extremes included
      run_phase(24'd0, 90, 1'b0);
      run_phase(24'd1, 90, 1'b0);
      run_phase(24'($urandom_range(2, 3000)), 90, 1'b0);
      // wear-out: accumulator crosses the longest lifetime and saturates;
      // the long result-side hold-off happens in here
      run_phase(24'hFFFFFF, 430, 1'b1);
      run_phase(24'($urandom), 90, 1'b0);
      run_phase(24'($urandom_range(100, 5000)), 90, 1'b0);

      req_valid <= 1'b0;
      do @(posedge clock); while (expected_rsp.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("testbench: clean");
      else
         $display("testbench: errors");
      $finish;
   end

endmodule
